// ----- design/fcip_pkg.sv -----
// fcip_pkg: shared types, constants and helpers for the friction cone projection core
// no dependencies
package fcip_pkg;

    localparam int SQRT_STEPS = 32;   // one root bit per stage
    localparam int DIV_STEPS  = 29;   // quotient bits of the direction, Q.28 up to 1.0

    localparam logic [1:0] CASE_NONE   = 2'd0;
    localparam logic [1:0] CASE_INSIDE = 2'd1;
    localparam logic [1:0] CASE_PROJ   = 2'd2;

    localparam logic [30:0] EPS_RESET = 31'd7;
    localparam logic        ADDR_EPS  = 1'b0;   // word index of velocity_epsilon

    typedef struct packed {
        logic        nocontact;
        logic        in_cone;
        logic [31:0] imp_t0;
        logic [31:0] imp_t1;
        logic [31:0] imp_n;
        logic        v0_neg;
        logic        v1_neg;
        logic        v0_zero;
        logic        v1_zero;
        logic [31:0] vmag0;
        logic [31:0] vmag1;
        logic [34:0] mq;
    } side_t;

    typedef struct packed {
        logic [31:0] t0;
        logic [31:0] t1;
        logic [31:0] n;
        logic [1:0]  code;
    } res_t;

    function automatic logic [31:0] abs32(input logic [31:0] x);
        abs32 = x[31] ? (~x + 32'd1) : x;
    endfunction

endpackage

// ----- design/friction_cone_impulse_projection_core.sv -----
// friction_cone_impulse_projection_core: top level, pipeline chain, output skid, apb register
// depends on fcip_pkg, fcip_front, fcip_sqrt, fcip_div, fcip_back
//
//   channel   handshake              payload
//   input     in_valid / in_ready    vel_t0 vel_t1 vel_n imp_t0 imp_t1 imp_n friction_coeff
//   output    out_valid / out_ready  out_t0 out_t1 out_n case_code
//   config    apb psel/penable/...   velocity_epsilon at byte address 0
//
// one transfer per cycle sustained while out_ready stays high; an input transfer reaches out_valid through
// 4 front stages, 32 root stages, 29 divide stages, 2 scale stages and 1 output register
// the root and divide chains retire one bit per stage and set the latency
// reset clears all valid bits and loads velocity_epsilon with 7; no clearing pass
// a stalled output pushes one more result into the skid register, then the whole
// pipeline holds; in_ready stays high while the skid register is empty
module friction_cone_impulse_projection_core import fcip_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] vel_t0,
    input  logic signed [31:0] vel_t1,
    input  logic signed [31:0] vel_n,
    input  logic signed [31:0] imp_t0,
    input  logic signed [31:0] imp_t1,
    input  logic signed [31:0] imp_n,
    input  logic        [19:0] friction_coeff,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_t0,
    output logic signed [31:0] out_t1,
    output logic signed [31:0] out_n,
    output logic        [1:0]  case_code,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [2:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    logic [30:0] eps_reg;

    // pipeline advance; the normal velocity takes no part in the result
    logic                 en;
    logic                 fr_valid, sq_valid, dv_valid, bk_valid;
    logic [63:0]          fr_n2;
    side_t                fr_side, sq_side, dv_side;
    logic [31:0]          sq_root;
    logic [DIV_STEPS-1:0] dv_q0, dv_q1;
    res_t                 bk_res;

    // output register and skid register
    logic out_valid_reg, skid_valid_reg;
    res_t out_res_reg, skid_res_reg;
    logic push, pop;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_EPS) ? {1'b0, eps_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_EPS))
            eps_reg <= pwdata[30:0];
    end

    // ---------------- pipeline ----------------
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    fcip_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (in_valid),
        .vel_t0         (vel_t0),
        .vel_t1         (vel_t1),
        .imp_t0         (imp_t0),
        .imp_t1         (imp_t1),
        .imp_n          (imp_n),
        .friction_coeff (friction_coeff),
        .eps            (eps_reg),
        .out_valid      (fr_valid),
        .out_n2         (fr_n2),
        .out_side       (fr_side)
    );

    fcip_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_n2     (fr_n2),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    fcip_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_q0    (dv_q0),
        .out_q1    (dv_q1),
        .out_side  (dv_side)
    );

    fcip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .in_q0     (dv_q0),
        .in_q1     (dv_q1),
        .in_side   (dv_side),
        .out_valid (bk_valid),
        .out_res   (bk_res)
    );

    // ---------------- output with skid ----------------
    assign pop  = out_valid_reg && out_ready;
    assign push = en && bk_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // pipeline held; drain skid once the output is taken
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_res_reg <= skid_res_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_res_reg <= bk_res;
            else
                out_res_reg <= bk_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_t0    = out_res_reg.t0;
    assign out_t1    = out_res_reg.t1;
    assign out_n     = out_res_reg.n;
    assign case_code = out_res_reg.code;

endmodule

// ----- design/fcip_front.sv -----
// fcip_front: magnitudes, squares, cone test and soft norm square (four stages)
// depends on fcip_pkg
module fcip_front import fcip_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] vel_t0,
    input  logic signed [31:0] vel_t1,
    input  logic signed [31:0] imp_t0,
    input  logic signed [31:0] imp_t1,
    input  logic signed [31:0] imp_n,
    input  logic        [19:0] friction_coeff,
    input  logic        [30:0] eps,
    output logic               out_valid,
    output logic        [63:0] out_n2,
    output side_t              out_side
);

    // stage 1
    logic        s1_valid_reg;
    logic [50:0] s1_m_reg;
    logic [31:0] s1_a0_reg, s1_a1_reg, s1_v0_reg, s1_v1_reg;
    logic [31:0] s1_g0_reg, s1_g1_reg, s1_pi_reg;
    logic        s1_noc_reg, s1_v0n_reg, s1_v1n_reg;
    // stage 2
    logic        s2_valid_reg;
    logic [63:0] s2_sa0_reg, s2_sa1_reg, s2_sv0_reg, s2_sv1_reg;
    logic [61:0] s2_se_reg;
    logic [49:0] s2_hh_reg;
    logic [50:0] s2_hl_reg;
    logic [51:0] s2_ll_reg;
    side_t       s2_side_reg;
    // stage 3
    logic        s3_valid_reg;
    logic [63:0] s3_s_reg, s3_n2_reg;
    logic [101:0] s3_msq_reg;
    side_t       s3_side_reg;
    // stage 4
    logic        s4_valid_reg;
    logic [63:0] s4_n2_reg;
    side_t       s4_side_reg;
    side_t       s4_side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_comb
    begin
        s4_side_next = s3_side_reg;
        s4_side_next.in_cone = {6'd0, s3_s_reg, 32'd0} <= s3_msq_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // mu * pi, only meaningful for positive pi
            s1_m_reg   <= 51'(friction_coeff * imp_n[30:0]);
            s1_a0_reg  <= abs32(imp_t0);
            s1_a1_reg  <= abs32(imp_t1);
            s1_v0_reg  <= abs32(vel_t0);
            s1_v1_reg  <= abs32(vel_t1);
            s1_g0_reg  <= imp_t0;
            s1_g1_reg  <= imp_t1;
            s1_pi_reg  <= imp_n;
            s1_noc_reg <= imp_n[31] || (imp_n == 32'sd0);
            s1_v0n_reg <= vel_t0[31];
            s1_v1n_reg <= vel_t1[31];

            s2_sa0_reg <= s1_a0_reg * s1_a0_reg;
            s2_sa1_reg <= s1_a1_reg * s1_a1_reg;
            s2_sv0_reg <= s1_v0_reg * s1_v0_reg;
            s2_sv1_reg <= s1_v1_reg * s1_v1_reg;
            s2_se_reg  <= eps * eps;
            s2_hh_reg  <= s1_m_reg[50:26] * s1_m_reg[50:26];
            s2_hl_reg  <= s1_m_reg[50:26] * s1_m_reg[25:0];
            s2_ll_reg  <= s1_m_reg[25:0] * s1_m_reg[25:0];
            s2_side_reg.nocontact <= s1_noc_reg;
            s2_side_reg.in_cone   <= 1'b0;
            s2_side_reg.imp_t0    <= s1_g0_reg;
            s2_side_reg.imp_t1    <= s1_g1_reg;
            s2_side_reg.imp_n     <= s1_pi_reg;
            s2_side_reg.v0_neg    <= s1_v0n_reg;
            s2_side_reg.v1_neg    <= s1_v1n_reg;
            s2_side_reg.v0_zero   <= (s1_v0_reg == 32'd0);
            s2_side_reg.v1_zero   <= (s1_v1_reg == 32'd0);
            s2_side_reg.vmag0     <= s1_v0_reg;
            s2_side_reg.vmag1     <= s1_v1_reg;
            s2_side_reg.mq        <= s1_m_reg[50:16];

            // exact m squared from partial products
            s3_s_reg    <= s2_sa0_reg + s2_sa1_reg;
            s3_msq_reg  <= {s2_hh_reg, 52'd0} + {24'd0, s2_hl_reg, 27'd0}
                           + {50'd0, s2_ll_reg};
            s3_n2_reg   <= s2_sv0_reg + s2_sv1_reg + {2'd0, s2_se_reg};
            s3_side_reg <= s2_side_reg;

            s4_n2_reg   <= s3_n2_reg;
            s4_side_reg <= s4_side_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_n2    = s4_n2_reg;
    assign out_side  = s4_side_reg;

endmodule

// ----- design/fcip_sqrt.sv -----
// fcip_sqrt: pipelined integer square root, one root bit per stage
// depends on fcip_pkg
module fcip_sqrt import fcip_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_n2,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [31:0] out_root,
    output side_t       out_side
);

    logic        valid_reg [SQRT_STEPS];
    logic [63:0] rem_reg   [SQRT_STEPS];
    logic [31:0] root_reg  [SQRT_STEPS];
    side_t       side_reg  [SQRT_STEPS];

    genvar k;
    for (k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam int Bit = SQRT_STEPS - 1 - k;
        logic        valid_in;
        logic [63:0] rem_in;
        logic [31:0] root_in;
        side_t       side_in;
        logic [65:0] trial;
        logic        take;

        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_n2;
            assign root_in  = 32'd0;
            assign side_in  = in_side;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        // (2*root + 2^bit) * 2^bit
        assign trial = ({34'd0, root_in} << (Bit + 1)) + (66'd1 << (2 * Bit));
        assign take  = {2'b00, rem_in} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? (rem_in - trial[63:0]) : rem_in;
                root_reg[k] <= take ? (root_in | (32'd1 << Bit)) : root_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign out_root  = root_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule

// ----- design/fcip_div.sv -----
// fcip_div: two-lane pipelined restoring divider, |v| * 2^28 / n, one bit per stage
// depends on fcip_pkg
module fcip_div import fcip_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [31:0]          in_root,
    input  side_t                in_side,
    output logic                 out_valid,
    output logic [DIV_STEPS-1:0] out_q0,
    output logic [DIV_STEPS-1:0] out_q1,
    output side_t                out_side
);

    logic                 valid_reg [DIV_STEPS];
    logic [31:0]          n_reg     [DIV_STEPS];
    logic [59:0]          rem0_reg  [DIV_STEPS];
    logic [59:0]          rem1_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] q0_reg    [DIV_STEPS];
    logic [DIV_STEPS-1:0] q1_reg    [DIV_STEPS];
    side_t                side_reg  [DIV_STEPS];

    genvar k;
    for (k = 0; k < DIV_STEPS; k++)
    begin : g_step
        localparam int Bit = DIV_STEPS - 1 - k;
        logic                 valid_in;
        logic [31:0]          n_in;
        logic [59:0]          rem0_in, rem1_in, dsh;
        logic [DIV_STEPS-1:0] q0_in, q1_in;
        side_t                side_in;
        logic                 take0, take1;

        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign n_in     = in_root;
            assign rem0_in  = {in_side.vmag0, 28'd0};
            assign rem1_in  = {in_side.vmag1, 28'd0};
            assign q0_in    = '0;
            assign q1_in    = '0;
            assign side_in  = in_side;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[k-1];
            assign n_in     = n_reg[k-1];
            assign rem0_in  = rem0_reg[k-1];
            assign rem1_in  = rem1_reg[k-1];
            assign q0_in    = q0_reg[k-1];
            assign q1_in    = q1_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        assign dsh   = {28'd0, n_in} << Bit;
        assign take0 = rem0_in >= dsh;
        assign take1 = rem1_in >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]    <= n_in;
                rem0_reg[k] <= take0 ? (rem0_in - dsh) : rem0_in;
                rem1_reg[k] <= take1 ? (rem1_in - dsh) : rem1_in;
                q0_reg[k]   <= q0_in | (DIV_STEPS'(take0) << Bit);
                q1_reg[k]   <= q1_in | (DIV_STEPS'(take1) << Bit);
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_q0    = q0_reg[DIV_STEPS-1];
    assign out_q1    = q1_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

// ----- design/fcip_back.sv -----
// fcip_back: scales the direction by mu*pi, saturates and picks the case (two stages)
// depends on fcip_pkg
module fcip_back import fcip_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DIV_STEPS-1:0] in_q0,
    input  logic [DIV_STEPS-1:0] in_q1,
    input  side_t                in_side,
    output logic                 out_valid,
    output res_t                 out_res
);

    logic        a_valid_reg;
    logic [45:0] a_hi0_reg, a_hi1_reg;
    logic [46:0] a_lo0_reg, a_lo1_reg;
    side_t       a_side_reg;
    logic        b_valid_reg;
    res_t        b_res_reg;
    res_t        b_res_next;
    logic [63:0] sum0, sum1;

    function automatic logic [31:0] proj(input logic [34:0] mag, input logic neg,
                                         input logic zero);
        logic [31:0] sat;
        sat = 32'd0;
        if (zero)
            sat = 32'd0;
        else if (neg)
            sat = (mag > 35'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        else
        begin
            sat = (mag > 35'h080000000) ? 32'h80000000 : mag[31:0];
            sat = ~sat + 32'd1;
        end
        return sat;
    endfunction

    assign sum0 = {a_hi0_reg, 18'd0} + {17'd0, a_lo0_reg};
    assign sum1 = {a_hi1_reg, 18'd0} + {17'd0, a_lo1_reg};

    always_comb
    begin
        if (a_side_reg.nocontact)
        begin
            b_res_next.t0   = 32'd0;
            b_res_next.t1   = 32'd0;
            b_res_next.n    = 32'd0;
            b_res_next.code = CASE_NONE;
        end
        else if (a_side_reg.in_cone)
        begin
            b_res_next.t0   = a_side_reg.imp_t0;
            b_res_next.t1   = a_side_reg.imp_t1;
            b_res_next.n    = a_side_reg.imp_n;
            b_res_next.code = CASE_INSIDE;
        end
        else
        begin
            b_res_next.t0   = proj(sum0[62:28], a_side_reg.v0_neg, a_side_reg.v0_zero);
            b_res_next.t1   = proj(sum1[62:28], a_side_reg.v1_neg, a_side_reg.v1_zero);
            b_res_next.n    = a_side_reg.imp_n;
            b_res_next.code = CASE_PROJ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // mq split 17 + 18 bits to keep each product narrow
            a_hi0_reg  <= in_side.mq[34:18] * in_q0;
            a_lo0_reg  <= in_side.mq[17:0] * in_q0;
            a_hi1_reg  <= in_side.mq[34:18] * in_q1;
            a_lo1_reg  <= in_side.mq[17:0] * in_q1;
            a_side_reg <= in_side;
            b_res_reg  <= b_res_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_res   = b_res_reg;

endmodule
